/* sv/cmrtc_pkg.sv */
`timescale 1ns / 1ps
package cmrtc_pkg;

  // bus addresses of the register window
  localparam logic [15:0] ADDR_DATA = 16'hA000;
  localparam logic [15:0] ADDR_CMD  = 16'hA001;
  localparam logic [15:0] WIN_LO    = 16'hA000;
  localparam logic [15:0] WIN_HI    = 16'hBFFF;

  // unlock sequence
  localparam logic [7:0] UNLOCK_KEY   = 8'h0A;
  localparam logic [7:0] UNLOCK_VALUE = 8'hF1;
  localparam logic [7:0] REG_A_VALUE  = 8'h01;

  // command nibbles
  localparam logic [3:0] CMD_BANK_LO = 4'h0;
  localparam logic [3:0] CMD_BANK_HI = 4'h1;
  localparam logic [3:0] CMD_RAM     = 4'h7;
  localparam logic [3:0] CMD_REG_A   = 4'hA;
  localparam logic [3:0] CMD_RAM_LO  = 4'hC;
  localparam logic [3:0] CMD_RAM_HI  = 4'hD;

  // register file slots that form the ram address and value
  localparam logic [3:0] REG_VAL_LO  = 4'h4;
  localparam logic [3:0] REG_VAL_HI  = 4'h5;
  localparam logic [3:0] REG_ADDR_LO = 4'h6;
  localparam logic [3:0] REG_ADDR_HI = 4'h7;

  // mapper ram
  localparam int RAM_DEPTH = 256;
  localparam int RAM_AW    = $clog2(RAM_DEPTH);
  localparam logic [RAM_AW-1:0] RAM_STORE_MAX = RAM_AW'(8'h10);

  // clock latch addresses
  localparam logic [RAM_AW-1:0] RTC_TRIG_A  = RAM_AW'(8'h08);
  localparam logic [RAM_AW-1:0] RTC_TRIG_B  = RAM_AW'(8'h28);
  localparam logic [RAM_AW-1:0] RTC_DIGIT   = RAM_AW'(8'h18);
  localparam logic [RAM_AW-1:0] RTC_SEC     = RAM_AW'(8'h54);
  localparam logic [RAM_AW-1:0] RTC_MIN     = RAM_AW'(8'h64);
  localparam logic [RAM_AW-1:0] RTC_HOUR    = RAM_AW'(8'h74);
  localparam logic [RAM_AW-1:0] RTC_DAY     = RAM_AW'(8'h84);
  localparam logic [RAM_AW-1:0] RTC_MONTH   = RAM_AW'(8'h94);

  // digit selectors for the single digit slot
  localparam logic [3:0] SEL_SEC_LO   = 4'h0;
  localparam logic [3:0] SEL_SEC_HI   = 4'h1;
  localparam logic [3:0] SEL_MIN_LO   = 4'h2;
  localparam logic [3:0] SEL_MIN_HI   = 4'h3;
  localparam logic [3:0] SEL_HOUR_LO  = 4'h4;
  localparam logic [3:0] SEL_HOUR_HI  = 4'h5;
  localparam logic [3:0] SEL_DAY_LO   = 4'h7;
  localparam logic [3:0] SEL_DAY_HI   = 4'h8;
  localparam logic [3:0] SEL_MON_LO   = 4'h9;
  localparam logic [3:0] SEL_MON_HI   = 4'hA;
  localparam logic [3:0] SEL_YEAR_TEN = 4'hB;
  localparam logic [3:0] SEL_YEAR_ONE = 4'hC;

  // clock write sequence slots
  localparam int TW_W = 3;
  localparam logic [TW_W-1:0] TW_DIGIT = 3'd0;
  localparam logic [TW_W-1:0] TW_SEC   = 3'd1;
  localparam logic [TW_W-1:0] TW_MIN   = 3'd2;
  localparam logic [TW_W-1:0] TW_HOUR  = 3'd3;
  localparam logic [TW_W-1:0] TW_DAY   = 3'd4;
  localparam logic [TW_W-1:0] TW_MONTH = 3'd5;
  localparam logic [TW_W-1:0] TW_LAST  = TW_MONTH;

  // configuration registers
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] CFG_HAS_RAM   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEC_OFF   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_OFF   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HOUR_OFF  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DAY_OFF   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MONTH_OFF = 3'd5;

  // controller to datapath commands
  typedef struct packed {
    logic            capture;
    logic            exec;
    logic            store;
    logic            time1;
    logic            time2;
    logic            time3;
    logic            twrite;
    logic [TW_W-1:0] widx;
    logic            load_out;
  } cmrtc_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic go_store;
    logic go_latch;
  } cmrtc_sts_t;

  // value below 128 mod 60
  function automatic logic [5:0] mod60(input logic [6:0] v);
    logic [6:0] r;
    if (v >= 7'd120) r = v - 7'd120;
    else if (v >= 7'd60) r = v - 7'd60;
    else r = v;
    return r[5:0];
  endfunction

  // value below 64 mod 24
  function automatic logic [4:0] mod24(input logic [5:0] v);
    logic [5:0] r;
    if (v >= 6'd48) r = v - 6'd48;
    else if (v >= 6'd24) r = v - 6'd24;
    else r = v;
    return r[4:0];
  endfunction

  // value below 32 mod 12
  function automatic logic [3:0] mod12(input logic [4:0] v);
    logic [4:0] r;
    if (v >= 5'd24) r = v - 5'd24;
    else if (v >= 5'd12) r = v - 5'd12;
    else r = v;
    return r[3:0];
  endfunction

  // two bcd digits of a value mod 100
  function automatic logic [7:0] to_bcd(input logic [8:0] v);
    logic [8:0] h;
    logic [6:0] r;
    logic [3:0] t;
    logic [6:0] u;
    if (v >= 9'd500) h = v - 9'd500;
    else if (v >= 9'd400) h = v - 9'd400;
    else if (v >= 9'd300) h = v - 9'd300;
    else if (v >= 9'd200) h = v - 9'd200;
    else if (v >= 9'd100) h = v - 9'd100;
    else h = v;
    r = h[6:0];
    t = 4'd0;
    for (int i = 1; i < 10; i++) begin
      if (r >= 7'(10 * i)) t = 4'(i);
    end
    u = r - 7'({t, 3'b000}) - 7'({t, 1'b0});
    return {t, u[3:0]};
  endfunction

endpackage

/* sv/cmrtc_req_if.sv */
`timescale 1ns / 1ps
interface cmrtc_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [15:0] address;
  logic [7:0] write_data;
  logic [5:0] now_second;
  logic [5:0] now_minute;
  logic [4:0] now_hour;
  logic [4:0] now_day;
  logic [3:0] now_month;
  logic [7:0] now_year;

  modport source (
    output valid, req_type, address, write_data, now_second, now_minute,
    output now_hour, now_day, now_month, now_year,
    input  ready
  );
  modport sink (
    input  valid, req_type, address, write_data, now_second, now_minute,
    input  now_hour, now_day, now_month, now_year,
    output ready
  );
endinterface

/* sv/cmrtc_rsp_if.sv */
`timescale 1ns / 1ps
interface cmrtc_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       window_hit;
  logic [7:0] rom_bank_now;

  modport source (output valid, read_data, window_hit, rom_bank_now, input ready);
  modport sink (input valid, read_data, window_hit, rom_bank_now, output ready);
endinterface

/* sv/cmrtc_cfg_if.sv */
`timescale 1ns / 1ps
interface cmrtc_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [8:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* sv/cartridge_mapper_rtc_regs_top.sv */
`timescale 1ns / 1ps
// Cartridge mapper register block with a small RAM and a clock latch.
// req carries one bus access per word (read or write, address, data and
// the current time); rsp returns one word per access: read data, window
// hit and the ROM bank after the access. cfg writes the RAM-present flag
// and the clock offsets; it is always ready. It is to be written only
// while idle; the user must keep to this, the block does not enforce it.
// One access is worked at a time by a controller stepping a datapath:
// capture, execute, then done; an access that stores to RAM adds a store
// step, and one that latches the clock adds three arithmetic steps, then
// up to six RAM writes through the single write port, one per cycle.
// The next access is accepted only after the last result is loaded.
// Reset clears the lock, command, bank, register file and offsets, and
// sets the RAM-present flag; RAM entries never written read as zero
// through per-entry valid bits, so no clearing pass follows reset.
// The result sits in an output register; if the receiver stalls, the
// controller holds the next result until that register frees up.
module cartridge_mapper_rtc_regs_top import cmrtc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  cmrtc_req_if.sink   req,
  cmrtc_rsp_if.source rsp,
  cmrtc_cfg_if.sink   cfg
);

  cmrtc_cmd_t cmd;
  cmrtc_sts_t sts;
  logic       out_valid;

  assign cfg.ready = 1'b1;
  assign rsp.valid = out_valid;

  // sequencer
  cmrtc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (out_valid),
    .out_ready (rsp.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // registers, ram and clock arithmetic
  cmrtc_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .req_type     (req.req_type),
    .address      (req.address),
    .write_data   (req.write_data),
    .now_second   (req.now_second),
    .now_minute   (req.now_minute),
    .now_hour     (req.now_hour),
    .now_day      (req.now_day),
    .now_month    (req.now_month),
    .now_year     (req.now_year),
    .cfg_we       (cfg.valid),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data),
    .read_data    (rsp.read_data),
    .window_hit   (rsp.window_hit),
    .rom_bank_now (rsp.rom_bank_now)
  );

endmodule

/* sv/cmrtc_ctrl.sv */
`timescale 1ns / 1ps
module cmrtc_ctrl import cmrtc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output cmrtc_cmd_t cmd,
  input  cmrtc_sts_t sts
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_EXEC   = 8'b0000_0010,
    S_STORE  = 8'b0000_0100,
    S_TIME1  = 8'b0000_1000,
    S_TIME2  = 8'b0001_0000,
    S_TIME3  = 8'b0010_0000,
    S_TWRITE = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  state_t          state, state_next;
  logic [TW_W-1:0] widx, widx_next;
  logic            slot_free;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE);

  // sequencing of one word
  always_comb begin
    state_next = state;
    widx_next  = widx;
    cmd        = '0;
    cmd.widx   = widx;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = sts.go_store ? S_STORE : S_DONE;
      end
      S_STORE: begin
        cmd.store  = 1'b1;
        state_next = sts.go_latch ? S_TIME1 : S_DONE;
      end
      S_TIME1: begin
        cmd.time1  = 1'b1;
        state_next = S_TIME2;
      end
      S_TIME2: begin
        cmd.time2  = 1'b1;
        state_next = S_TIME3;
      end
      S_TIME3: begin
        cmd.time3  = 1'b1;
        widx_next  = TW_DIGIT;
        state_next = S_TWRITE;
      end
      S_TWRITE: begin
        cmd.twrite = 1'b1;
        widx_next  = widx + 1'b1;
        if (widx == TW_LAST) state_next = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      widx      <= TW_DIGIT;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      widx  <= widx_next;
      if (cmd.load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

/* sv/cmrtc_dp.sv */
`timescale 1ns / 1ps
module cmrtc_dp import cmrtc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  cmrtc_cmd_t            cmd,
  output cmrtc_sts_t            sts,
  input  logic                  req_type,
  input  logic [15:0]           address,
  input  logic [7:0]            write_data,
  input  logic [5:0]            now_second,
  input  logic [5:0]            now_minute,
  input  logic [4:0]            now_hour,
  input  logic [4:0]            now_day,
  input  logic [3:0]            now_month,
  input  logic [7:0]            now_year,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic [7:0]            read_data,
  output logic                  window_hit,
  output logic [7:0]            rom_bank_now
);

  // configuration registers
  logic       has_ram;
  logic [5:0] sec_off, min_off;
  logic [4:0] hour_off;
  logic [8:0] day_off;
  logic [3:0] mon_off;

  always_ff @(posedge clk) begin
    if (rst) begin
      has_ram  <= 1'b1;
      sec_off  <= '0;
      min_off  <= '0;
      hour_off <= '0;
      day_off  <= '0;
      mon_off  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HAS_RAM:   has_ram  <= cfg_data[0];
        CFG_SEC_OFF:   sec_off  <= cfg_data[5:0];
        CFG_MIN_OFF:   min_off  <= cfg_data[5:0];
        CFG_HOUR_OFF:  hour_off <= cfg_data[4:0];
        CFG_DAY_OFF:   day_off  <= cfg_data[8:0];
        CFG_MONTH_OFF: mon_off  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // captured access
  logic        is_wr;
  logic [15:0] addr_q;
  logic [7:0]  data_q;
  logic [5:0]  sec_q, min_q;
  logic [4:0]  hour_q, day_q;
  logic [3:0]  mon_q;
  logic [7:0]  year_q;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      is_wr  <= req_type;
      addr_q <= address;
      data_q <= write_data;
      sec_q  <= now_second;
      min_q  <= now_minute;
      hour_q <= now_hour;
      day_q  <= now_day;
      mon_q  <= now_month;
      year_q <= now_year;
    end
  end

  // mapper state
  logic       unlocked;
  logic [3:0] command;
  logic [7:0] bank;
  logic [7:0] reg_file [16];

  // access decode
  logic hit, wr_en, unlock_op, cmd_op, dat_op, rd_op;

  assign hit       = (addr_q >= WIN_LO) && (addr_q <= WIN_HI);
  assign wr_en     = is_wr && hit && has_ram;
  assign unlock_op = wr_en && (addr_q == ADDR_CMD) && (data_q == UNLOCK_KEY) && !unlocked;
  assign cmd_op    = wr_en && !unlock_op && unlocked && (addr_q == ADDR_CMD);
  assign dat_op    = wr_en && unlocked && (addr_q == ADDR_DATA);
  assign rd_op     = !is_wr && hit && unlocked && (addr_q == ADDR_DATA);

  // ram address and value from the register file
  logic [RAM_AW-1:0] ra;
  logic [7:0]        val;
  logic              latch_hit;

  assign ra  = {reg_file[REG_ADDR_HI][3:0], 4'h0} | reg_file[REG_ADDR_LO];
  assign val = {reg_file[REG_VAL_HI][3:0], 4'h0} | reg_file[REG_VAL_LO];
  assign latch_hit = (ra == RTC_TRIG_A) || (ra == RTC_TRIG_B) || (ra == RTC_DIGIT) ||
                     (ra == RTC_SEC) || (ra == RTC_MIN) || (ra == RTC_HOUR) ||
                     (ra == RTC_DAY) || (ra == RTC_MONTH);

  assign sts.go_store = dat_op && (command == CMD_RAM);
  assign sts.go_latch = latch_hit;

  // mapper ram, entries never written read as zero
  logic [7:0]        mem [RAM_DEPTH];
  logic [RAM_DEPTH-1:0] ram_valid;
  logic [7:0]        ram_rdata;
  logic              ram_rvld;
  logic [7:0]        ram_word;
  logic              we;
  logic [RAM_AW-1:0] waddr;
  logic [7:0]        wdata;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    ram_rdata <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ram_valid <= '0;
      ram_rvld  <= 1'b0;
    end else begin
      if (we) ram_valid[waddr] <= 1'b1;
      ram_rvld <= ram_valid[ra];
    end
  end

  assign ram_word = ram_rvld ? ram_rdata : 8'h00;

  // register file, command and bank updates
  always_ff @(posedge clk) begin
    if (rst) begin
      unlocked <= 1'b0;
      command  <= '0;
      bank     <= '0;
      for (int i = 0; i < 16; i++) reg_file[i] <= '0;
    end else if (cmd.exec) begin
      if (unlock_op) begin
        reg_file[CMD_REG_A] <= UNLOCK_VALUE;
        unlocked            <= 1'b1;
      end else if (cmd_op) begin
        command <= data_q[3:0];
        if (data_q[3:0] == CMD_RAM_LO) reg_file[CMD_RAM_LO] <= {4'h0, ram_word[3:0]};
        else if (data_q[3:0] == CMD_RAM_HI) reg_file[CMD_RAM_HI] <= {4'h0, ram_word[7:4]};
      end else if (dat_op) begin
        if (command == CMD_REG_A) reg_file[command] <= REG_A_VALUE;
        else reg_file[command] <= {4'h0, data_q[3:0]};
        if (command == CMD_BANK_LO) bank <= {bank[7:4], data_q[3:0]};
        else if (command == CMD_BANK_HI) bank <= {data_q[3:0], bank[3:0]};
      end
    end
  end

  // clock arithmetic, step one: seconds and minutes
  logic [6:0] sec_sum, min_sum;
  logic       sec_c;
  logic [5:0] sec_t, min_t;
  logic       min_c;

  assign sec_sum = {1'b0, sec_q} + {1'b0, sec_off};
  assign sec_c   = sec_sum >= 7'd60;
  assign min_sum = {1'b0, min_q} + {1'b0, min_off} + {6'd0, sec_c};

  always_ff @(posedge clk) begin
    if (cmd.time1) begin
      sec_t <= mod60(sec_sum);
      min_t <= mod60(min_sum);
      min_c <= min_sum >= 7'd60;
    end
  end

  // step two: hours, day, month and year
  logic [5:0] hour_sum;
  logic       hour_c;
  logic [9:0] day_sum;
  logic [9:0] day_red;
  logic [4:0] mon_sum;
  logic [3:0] mon_mod;
  logic       year_inc;
  logic [4:0] hour_t;
  logic [8:0] day_t;
  logic [3:0] mon_t;
  logic [8:0] year_t;

  assign hour_sum = {1'b0, hour_q} + {1'b0, hour_off} + {5'd0, min_c};
  assign hour_c   = hour_sum >= 6'd24;
  assign day_sum  = {5'd0, day_q} + {1'b0, day_off} + {9'd0, hour_c};
  assign day_red  = (day_sum >= 10'd366) ? (day_sum - 10'd366) : day_sum;
  assign mon_sum  = {1'b0, mon_q} + {1'b0, mon_off} + 5'd1;
  assign year_inc = mon_sum >= 5'd12;
  assign mon_mod  = mod12(mon_sum);

  always_ff @(posedge clk) begin
    if (cmd.time2) begin
      hour_t <= mod24(hour_sum);
      day_t  <= day_red[8:0];
      mon_t  <= (mon_mod == 4'd0) ? 4'd1 : mon_mod;
      year_t <= {1'b0, year_q} + {8'd0, year_inc};
    end
  end

  // step three: bcd coding
  logic [7:0] bcd_s, bcd_m, bcd_h, bcd_d, bcd_mo, bcd_y;

  always_ff @(posedge clk) begin
    if (cmd.time3) begin
      bcd_s  <= to_bcd({3'd0, sec_t});
      bcd_m  <= to_bcd({3'd0, min_t});
      bcd_h  <= to_bcd({4'd0, hour_t});
      bcd_d  <= to_bcd(day_t);
      bcd_mo <= to_bcd({5'd0, mon_t});
      bcd_y  <= to_bcd(year_t);
    end
  end

  // selected digit for the digit slot
  logic [7:0] digit;
  logic       dig_en;

  always_comb begin
    digit  = 8'h00;
    dig_en = 1'b1;
    case (val[3:0])
      SEL_SEC_LO:   digit = {4'h0, bcd_s[3:0]};
      SEL_SEC_HI:   digit = {4'h0, bcd_s[7:4]};
      SEL_MIN_LO:   digit = {4'h0, bcd_m[3:0]};
      SEL_MIN_HI:   digit = {4'h0, bcd_m[7:4]};
      SEL_HOUR_LO:  digit = {4'h0, bcd_h[3:0]};
      SEL_HOUR_HI:  digit = {4'h0, bcd_h[7:4]};
      SEL_DAY_LO:   digit = {4'h0, bcd_d[3:0]};
      SEL_DAY_HI:   digit = {4'h0, bcd_d[7:4]};
      SEL_MON_LO:   digit = {4'h0, bcd_mo[3:0]};
      SEL_MON_HI:   digit = {4'h0, bcd_mo[7:4]};
      SEL_YEAR_TEN: digit = {4'h0, bcd_y[7:4]};
      SEL_YEAR_ONE: digit = {4'h0, bcd_y[3:0]};
      default:      dig_en = 1'b0;
    endcase
  end

  // ram write port: plain store or clock write sequence
  always_comb begin
    we    = 1'b0;
    waddr = ra;
    wdata = val;
    if (cmd.store && !latch_hit && (ra <= RAM_STORE_MAX)) we = 1'b1;
    if (cmd.twrite) begin
      we = 1'b1;
      case (cmd.widx)
        TW_DIGIT: begin
          waddr = RTC_DIGIT;
          wdata = digit;
          we    = dig_en;
        end
        TW_SEC: begin
          waddr = RTC_SEC;
          wdata = bcd_s;
        end
        TW_MIN: begin
          waddr = RTC_MIN;
          wdata = bcd_m;
        end
        TW_HOUR: begin
          waddr = RTC_HOUR;
          wdata = bcd_h;
        end
        TW_DAY: begin
          waddr = RTC_DAY;
          wdata = bcd_d;
        end
        TW_MONTH: begin
          waddr = RTC_MONTH;
          wdata = bcd_mo;
        end
        default: we = 1'b0;
      endcase
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      read_data    <= rd_op ? reg_file[command] : 8'h00;
      window_hit   <= hit;
      rom_bank_now <= bank;
    end
  end

endmodule
